FILE: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_top.
package spq_pkg;

    typedef logic signed [31:0] t_value;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DEQ_EMPTY = 2'd1,
        ST_ENQ_FULL  = 2'd2
    } t_status;

    // Broadcast from the queue controller to every cell.
    typedef struct packed {
        logic   en;   // apply the operation this cycle
        logic   deq;  // 1 shift towards the head, 0 insert the key
        t_value key;  // value being inserted
    } t_cell_ctrl;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds a value and updates it from its neighbours.
// Depends on spq_pkg.
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_valid,
    input  logic                i_left_ge,
    input  spq_pkg::t_value     i_left_value,
    input  spq_pkg::t_value     i_right_value,
    output spq_pkg::t_value     o_value,
    output logic                o_ge
);

    spq_pkg::t_value r_value;
    spq_pkg::t_value n_value;

    // Flag a stored value that stays ahead of the key
    assign o_ge    = i_valid && (r_value >= i_ctrl.key);
    assign o_value = r_value;

    // Pick the next value: keep, take the key, or take a neighbour
    always_comb begin
        n_value = r_value;
        if (i_ctrl.en) begin
            if (i_ctrl.deq) begin
                n_value = i_right_value;
            end else if (o_ge) begin
                n_value = r_value;
            end else if (i_left_ge) begin
                n_value = i_ctrl.key;
            end else begin
                n_value = i_left_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: rtl/sorted_priority_queue_top.sv
// Sorted max-priority queue: a row of spq_cell slots plus the count and result logic.
// Depends on spq_pkg and spq_cell.
//
// The queue takes one request per clock cycle: busy never rises, and each request
// (enqueue or dequeue) is applied by every cell at once, each cell comparing the key
// with its own value and its left neighbour's flag, then keeping, taking the key or
// shifting. The result is registered onto the o_ ports, with o_valid high in the cycle
// after the request and for a single cycle only; the receiver cannot stall it,
// so it must take every result as it comes. Equal values leave in arrival order. An
// enqueue into a full queue is dropped (status 2) and a dequeue from an empty queue
// is ignored (status 1). Reset clears only the count and o_valid; no clearing pass is needed.
module sorted_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_req_type,
    input  logic signed [31:0]  i_value,
    output logic                o_valid,
    output logic signed [31:0]  o_top_value,
    output logic signed [31:0]  o_removed_value,
    output logic [4:0]          o_entry_count,
    output logic                o_is_empty,
    output logic                o_is_full,
    output logic [1:0]          o_status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    spq_pkg::t_cell_ctrl w_ctrl;
    spq_pkg::t_value     w_value [CAPACITY];
    logic                w_ge    [CAPACITY];
    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic                w_enq_ok;
    logic                w_deq_ok;
    spq_pkg::t_value     n_top;
    spq_pkg::t_value     n_removed;
    spq_pkg::t_status    n_status;
    logic [CW+4:0]       w_count_ext;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CAP_C);
    assign w_empty  = (r_count == '0);
    assign w_enq_ok = w_accept && !i_req_type && !w_full;
    assign w_deq_ok = w_accept && i_req_type && !w_empty;

    assign w_ctrl.en  = w_enq_ok || w_deq_ok;
    assign w_ctrl.deq = i_req_type;
    assign w_ctrl.key = i_value;

    // Build the chain of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(gi);
        logic            w_valid;
        logic            w_left_ge;
        spq_pkg::t_value w_left;
        spq_pkg::t_value w_right;

        assign w_valid = (r_count > IDX);
        if (gi == 0) begin : g_head
            assign w_left_ge = 1'b1;
            assign w_left    = i_value;
        end else begin : g_body
            assign w_left_ge = w_ge[gi-1];
            assign w_left    = w_value[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = w_value[gi];
        end else begin : g_inner
            assign w_right = w_value[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_valid       (w_valid),
            .i_left_ge     (w_left_ge),
            .i_left_value  (w_left),
            .i_right_value (w_right),
            .o_value       (w_value[gi]),
            .o_ge          (w_ge[gi])
        );
    end

    // Work out the count, head, removed value and status after the request
    always_comb begin
        n_count   = r_count;
        n_top     = '0;
        n_removed = '0;
        n_status  = spq_pkg::ST_OK;
        if (w_enq_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_deq_ok) begin
            n_count = r_count - CW'(1);
        end
        if (!i_req_type) begin
            if (w_full) begin
                n_status = spq_pkg::ST_ENQ_FULL;
                n_top    = w_value[0];
            end else if (w_empty || (i_value > w_value[0])) begin
                n_top = i_value;
            end else begin
                n_top = w_value[0];
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_DEQ_EMPTY;
            end else begin
                n_removed = w_value[0];
                if (r_count > CW'(1)) begin
                    n_top = w_value[1];
                end
            end
        end
    end

    assign w_count_ext = {5'b0, n_count};

    // Hold the count and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
        o_top_value     <= n_top;
        o_removed_value <= n_removed;
        o_entry_count   <= w_count_ext[4:0];
        o_is_empty      <= (n_count == '0);
        o_is_full       <= (n_count == CAP_C);
        o_status        <= n_status;
    end

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("queue count above capacity");

    // Every request gives exactly one result in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_valid)
        else $error("result without request");

    // A rejected dequeue only happens on an empty queue and removes nothing
    a_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == spq_pkg::ST_DEQ_EMPTY)) |->
            (o_is_empty && (o_removed_value == '0)))
        else $error("dequeue error on non-empty queue");

    // A successful enqueue leaves a head no smaller than the inserted value
    a_enq_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_enq_ok |=> (o_top_value >= $past(i_value)))
        else $error("head below inserted value");

endmodule
